[hdl/simcc_keypoint_decoder_defines.svh]
// Assertion macros for the SimCC keypoint decoder
`ifndef SIMCC_KEYPOINT_DECODER_DEFINES_SVH
`define SIMCC_KEYPOINT_DECODER_DEFINES_SVH
`ifndef SYNTH
`define SKD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SKD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SKD_ASSERT_IMP(lbl, ante, cons, msg)
`define SKD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/skd_pkg.sv]
// Shared constants and types for the SimCC keypoint decoder
package skd_pkg;

  localparam int unsigned BOX_W      = 12;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned LOGIT_W    = 16;
  localparam int unsigned COORD_W    = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_RIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_BOTTOM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_HEIGHT = 3'd5;

  localparam logic [DIM_W-1:0] MODEL_WIDTH_RST  = 11'd192;
  localparam logic [DIM_W-1:0] MODEL_HEIGHT_RST = 11'd256;

  typedef struct packed {
    logic [BOX_W-1:0] box_left;
    logic [BOX_W-1:0] box_top;
    logic [BOX_W-1:0] box_right;
    logic [BOX_W-1:0] box_bottom;
    logic [DIM_W-1:0] model_width;
    logic [DIM_W-1:0] model_height;
  } cfg_t;

endpackage

[hdl/skd_front.sv]
// Front end: per-axis running argmax over the logit stream, emits one job per keypoint
module skd_front import skd_pkg::*; #(
  parameter int unsigned MAX_BINS = 1024,
  localparam int unsigned PW = $clog2(MAX_BINS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [LOGIT_W-1:0] logit_i,
  input  logic                      axis_i,
  input  logic                      last_bin_i,
  output logic                      push_o,
  input  logic                      full_i,
  output logic [PW-1:0]             pos_x_o,
  output logic [PW-1:0]             pos_y_o,
  output logic signed [LOGIT_W-1:0] score_o
);

  localparam logic [PW-1:0] CNT_MAX = PW'(MAX_BINS - 1);

  logic signed [LOGIT_W-1:0] bxv_q, bxv_d, byv_q, byv_d;
  logic [PW-1:0]             bxp_q, bxp_d, byp_q, byp_d;
  logic [PW-1:0]             cnt_q, cnt_d;
  logic                      accept, first_bin, take_x, take_y;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign first_bin  = (cnt_q == '0);
  assign take_x     = !axis_i && (first_bin || (logit_i > bxv_q));
  assign take_y     = axis_i && (first_bin || (logit_i > byv_q));

  always_comb begin
    bxv_d = take_x ? logit_i : bxv_q;
    bxp_d = take_x ? cnt_q : bxp_q;
    byv_d = take_y ? logit_i : byv_q;
    byp_d = take_y ? cnt_q : byp_q;
    if (last_bin_i) begin
      cnt_d = '0;
    end else if (cnt_q != CNT_MAX) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bxv_q <= '0;
      bxp_q <= '0;
      byv_q <= '0;
      byp_q <= '0;
      cnt_q <= '0;
    end else if (accept) begin
      bxv_q <= bxv_d;
      bxp_q <= bxp_d;
      byv_q <= byv_d;
      byp_q <= byp_d;
      cnt_q <= cnt_d;
    end
  end

  assign push_o  = accept && axis_i && last_bin_i;
  assign pos_x_o = bxp_d;
  assign pos_y_o = byp_d;
  assign score_o = (bxv_d < byv_d) ? bxv_d : byv_d;

endmodule

[hdl/skd_fifo.sv]
// Small job queue between front end and back end
module skd_fifo #(
  parameter int unsigned DATA_W = 36,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              empty_o
);

  localparam int unsigned PTRW = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam logic [PTRW-1:0] PTR_LAST = PTRW'(DEPTH - 1);
  localparam logic [CW-1:0]   CNT_FULL = CW'(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTRW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;

  assign full_o  = (count_q == CNT_FULL);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[hdl/skd_back.sv]
// Back end: crop selection, coordinate rescale with serial rounding divider, output register
module skd_back import skd_pkg::*; #(
  parameter int unsigned PW = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      job_valid_i,
  output logic                      job_pop_o,
  input  logic [PW-1:0]             pos_x_i,
  input  logic [PW-1:0]             pos_y_i,
  input  logic signed [LOGIT_W-1:0] score_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COORD_W-1:0] kpt_x_o,
  output logic signed [COORD_W-1:0] kpt_y_o,
  output logic signed [LOGIT_W-1:0] score_o,
  output logic                      saturated_o
);

  localparam int unsigned DW   = ((PW > DIM_W) ? PW : DIM_W) + 2;
  localparam int unsigned SW   = BOX_W + 1;
  localparam int unsigned PDW  = SW + DIM_W + 1;
  localparam int unsigned PRW  = SW + DW;
  localparam int unsigned CPW  = SW + DIM_W;
  localparam int unsigned NW   = PRW + 5;
  localparam int unsigned AW   = NW + 2;
  localparam int unsigned QW   = AW + 1;
  localparam int unsigned RW   = DIM_W + 2;
  localparam int unsigned CNTW = $clog2(AW);

  localparam logic signed [QW-1:0] SAT_MAX = QW'(524287);
  localparam logic signed [QW-1:0] SAT_MIN = -QW'(524288);
  localparam logic [CNTW-1:0]      DIV_LAST = CNTW'(AW - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CMP  = 4'd1;
  localparam logic [3:0] ST_SEL  = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_NUM  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_FIX  = 4'd6;
  localparam logic [3:0] ST_OUT  = 4'd7;

  logic [3:0] state_q;
  logic       out_valid_q;

  logic signed [PW:0]          qx_q, qy_q;
  logic signed [LOGIT_W-1:0]   score_q;
  logic signed [PDW-1:0]       p1_q, p2_q;
  logic [DIM_W-1:0]            d_q;
  logic signed [SW-1:0]        s_q;
  logic                        axis_q;
  logic signed [PRW-1:0]       t_q;
  logic [CPW-1:0]              c_q;
  logic                        neg_q;
  logic [AW-1:0]               dvd_q;
  logic [RW-1:0]               rem_q;
  logic [CNTW-1:0]             cnt_q;
  logic signed [COORD_W-1:0]   kx_q, ky_q;
  logic                        clip_q;
  logic signed [COORD_W-1:0]   kx_out_q, ky_out_q;
  logic signed [LOGIT_W-1:0]   score_out_q;
  logic                        sat_out_q;

  logic [DIM_W-1:0]      w_eff, h_eff, m_sel;
  logic signed [SW-1:0]  dx, dy;
  logic signed [PW:0]    q_sel;
  logic signed [DW-1:0]  diff;
  logic [SW-1:0]         edge_sum;
  logic signed [NW-1:0]  num;
  logic signed [AW-1:0]  a_val;
  logic [RW-1:0]         rem_sh, div_b;
  logic                  ge;
  logic signed [QW-1:0]  q_signed;
  logic signed [COORD_W-1:0] q_sat;
  logic                  q_clip;
  logic                  out_free;

  assign w_eff = (cfg_i.model_width == '0) ? DIM_W'(1) : cfg_i.model_width;
  assign h_eff = (cfg_i.model_height == '0) ? DIM_W'(1) : cfg_i.model_height;
  assign dx = $signed({1'b0, cfg_i.box_right}) - $signed({1'b0, cfg_i.box_left});
  assign dy = $signed({1'b0, cfg_i.box_bottom}) - $signed({1'b0, cfg_i.box_top});

  assign q_sel    = axis_q ? qy_q : qx_q;
  assign m_sel    = axis_q ? h_eff : w_eff;
  assign diff     = DW'(q_sel) - DW'($signed({1'b0, m_sel}));
  assign edge_sum = axis_q ? (SW'(cfg_i.box_top) + SW'(cfg_i.box_bottom))
                           : (SW'(cfg_i.box_left) + SW'(cfg_i.box_right));

  // 10*t + 8*c, then 2n + d for round-half-up
  assign num   = (NW'(t_q) <<< 3) + (NW'(t_q) <<< 1) + (NW'($signed({1'b0, c_q})) <<< 3);
  assign a_val = (AW'(num) <<< 1) + AW'($signed({1'b0, d_q}));

  assign rem_sh = {rem_q[RW-2:0], dvd_q[AW-1]};
  assign div_b  = RW'({d_q, 1'b0});
  assign ge     = (rem_sh >= div_b);

  always_comb begin
    if (neg_q) begin
      q_signed = -$signed({1'b0, dvd_q}) - QW'(rem_q != '0);
    end else begin
      q_signed = $signed({1'b0, dvd_q});
    end
    q_clip = 1'b0;
    if (q_signed > SAT_MAX) begin
      q_sat  = SAT_MAX[COORD_W-1:0];
      q_clip = 1'b1;
    end else if (q_signed < SAT_MIN) begin
      q_sat  = SAT_MIN[COORD_W-1:0];
      q_clip = 1'b1;
    end else begin
      q_sat = q_signed[COORD_W-1:0];
    end
  end

  assign out_free  = !out_valid_q || !out_stall_i;
  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (job_valid_i) state_q <= ST_CMP;
        ST_CMP:  state_q <= ST_SEL;
        ST_SEL:  state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_NUM;
        ST_NUM:  state_q <= ST_DIV;
        ST_DIV:  if (cnt_q == '0) state_q <= ST_FIX;
        ST_FIX:  state_q <= axis_q ? ST_OUT : ST_MUL;
        ST_OUT:  if (out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          qx_q    <= (score_i > 0) ? $signed({1'b0, pos_x_i}) : '1;
          qy_q    <= (score_i > 0) ? $signed({1'b0, pos_y_i}) : '1;
          score_q <= score_i;
          clip_q  <= 1'b0;
        end
      end
      ST_CMP: begin
        p1_q <= PDW'(dx) * PDW'($signed({1'b0, h_eff}));
        p2_q <= PDW'(dy) * PDW'($signed({1'b0, w_eff}));
      end
      ST_SEL: begin
        axis_q <= 1'b0;
        if (p1_q > p2_q) begin
          d_q <= w_eff;
          s_q <= dx;
        end else begin
          d_q <= h_eff;
          s_q <= dy;
        end
      end
      ST_MUL: begin
        t_q <= PRW'(s_q) * PRW'(diff);
        c_q <= CPW'(edge_sum) * CPW'(d_q);
      end
      ST_NUM: begin
        neg_q <= a_val[AW-1];
        dvd_q <= a_val[AW-1] ? AW'(-a_val) : AW'(a_val);
        rem_q <= '0;
        cnt_q <= DIV_LAST;
      end
      ST_DIV: begin
        rem_q <= ge ? (rem_sh - div_b) : rem_sh;
        dvd_q <= {dvd_q[AW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
      end
      ST_FIX: begin
        if (axis_q) begin
          ky_q <= q_sat;
        end else begin
          kx_q <= q_sat;
        end
        clip_q <= clip_q | q_clip;
        axis_q <= 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          kx_out_q    <= kx_q;
          ky_out_q    <= ky_q;
          score_out_q <= score_q;
          sat_out_q   <= clip_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign kpt_x_o     = kx_out_q;
  assign kpt_y_o     = ky_out_q;
  assign score_o     = score_out_q;
  assign saturated_o = sat_out_q;

endmodule

[hdl/simcc_keypoint_decoder.sv]
// Top level of the SimCC keypoint decoder: config registers, front end, job queue, back end
//
// Usage: logit bins enter on the input channel (in_valid_i / in_stall_o), all x bins of a
// keypoint then all y bins, last_bin_i marking the end of each axis. A transfer happens
// when valid is high and stall is low. The front end takes one bin per cycle and keeps
// the per-axis argmax; the last y bin pushes one job into a queue of QUEUE_DEPTH entries.
// The back end turns each job into one keypoint (kpt_x_o, kpt_y_o, score_o, saturated_o)
// on the output channel (out_valid_o / out_stall_i), held in an output register.
// The back end runs a one-bit-per-cycle rounding divider once per axis; AW, its dividend
// width, is 33 at MAX_BINS = 1024. The back end takes a new job only while it is idle,
// so keypoints are decoded one at a time.
// Bins are taken every cycle while the queue has room; in_stall_o rises when it is full.
// A stalled output holds its keypoint and the back end waits; the queue then fills.
// Reset clears the argmax state, the queue and the output valid, and sets the box to 0
// and the model size to 192 x 256. Config writes (cfg_we_i) take effect at once and are
// meant for idle periods only.
`include "simcc_keypoint_decoder_defines.svh"
module simcc_keypoint_decoder import skd_pkg::*; #(
  parameter int unsigned MAX_BINS    = 1024,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [LOGIT_W-1:0] logit_i,
  input  logic                      axis_i,
  input  logic                      last_bin_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COORD_W-1:0] kpt_x_o,
  output logic signed [COORD_W-1:0] kpt_y_o,
  output logic signed [LOGIT_W-1:0] score_o,
  output logic                      saturated_o
);

  localparam int unsigned PW    = $clog2(MAX_BINS);
  localparam int unsigned JOB_W = 2 * PW + LOGIT_W;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_left     <= '0;
      cfg_q.box_top      <= '0;
      cfg_q.box_right    <= '0;
      cfg_q.box_bottom   <= '0;
      cfg_q.model_width  <= MODEL_WIDTH_RST;
      cfg_q.model_height <= MODEL_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BOX_LEFT:     cfg_q.box_left     <= cfg_data_i[BOX_W-1:0];
        CFG_BOX_TOP:      cfg_q.box_top      <= cfg_data_i[BOX_W-1:0];
        CFG_BOX_RIGHT:    cfg_q.box_right    <= cfg_data_i[BOX_W-1:0];
        CFG_BOX_BOTTOM:   cfg_q.box_bottom   <= cfg_data_i[BOX_W-1:0];
        CFG_MODEL_WIDTH:  cfg_q.model_width  <= cfg_data_i[DIM_W-1:0];
        CFG_MODEL_HEIGHT: cfg_q.model_height <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic                      q_push, q_full, q_pop, q_empty;
  logic [PW-1:0]             f_pos_x, f_pos_y, b_pos_x, b_pos_y;
  logic signed [LOGIT_W-1:0] f_score, b_score;
  logic [JOB_W-1:0]          q_rdata;

  skd_front #(
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .logit_i    (logit_i),
    .axis_i     (axis_i),
    .last_bin_i (last_bin_i),
    .push_o     (q_push),
    .full_i     (q_full),
    .pos_x_o    (f_pos_x),
    .pos_y_o    (f_pos_y),
    .score_o    (f_score)
  );

  skd_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_pos_x, f_pos_y, f_score}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign b_pos_x = q_rdata[JOB_W-1 -: PW];
  assign b_pos_y = q_rdata[LOGIT_W+PW-1 -: PW];
  assign b_score = q_rdata[LOGIT_W-1:0];

  skd_back #(
    .PW (PW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (!q_empty),
    .job_pop_o   (q_pop),
    .pos_x_i     (b_pos_x),
    .pos_y_i     (b_pos_y),
    .score_i     (b_score),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kpt_x_o     (kpt_x_o),
    .kpt_y_o     (kpt_y_o),
    .score_o     (score_o),
    .saturated_o (saturated_o)
  );

  `SKD_ASSERT_IMP(a_push_not_full, q_push, !q_full, "job pushed into full queue")
  `SKD_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty, "job popped from empty queue")
  `SKD_ASSERT_IMP(a_last_y, in_valid_i && !in_stall_o && axis_i && last_bin_i, q_push, "lost job")
  `SKD_ASSERT_NXT(a_single_pop, q_pop, !q_pop, "back end popped two jobs in a row")

endmodule
